### design/worker_state_residency_counter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the worker state residency counter
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef WORKER_STATE_RESIDENCY_COUNTER_CORE_DEFINES_SVH
`define WORKER_STATE_RESIDENCY_COUNTER_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define WSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define WSRC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/wsrc_pkg.sv
// ----------------------------------------------------------------------------
// Worker state residency counter package
// Payload types, event codes, state codes and the event classification table.
// ----------------------------------------------------------------------------
package wsrc_pkg;

  localparam int TS_W         = 64;
  localparam int CNT_W        = 32;
  localparam int WID_W        = 4;
  localparam int KIND_W       = 5;
  localparam int DEF_WORKERS  = 16;
  localparam int DEF_Q_DEPTH  = 4;

  typedef enum logic [1:0] {
    ST_DEAD  = 2'd0,
    ST_WAIT  = 2'd1,
    ST_RUN   = 2'd2,
    ST_OTHER = 2'd3
  } state_e_t;

  typedef enum logic [2:0] {
    FX_NONE    = 3'd0,
    FX_START   = 3'd1,
    FX_END     = 3'd2,
    FX_BLOCK   = 3'd3,
    FX_SSTART  = 3'd4,
    FX_SUPDATE = 3'd5,
    FX_SDIE    = 3'd6,
    FX_SSTAB   = 3'd7
  } effect_t;

  localparam logic [KIND_W-1:0] EV_SCHED_START    = 5'd0;
  localparam logic [KIND_W-1:0] EV_SCHED_SHUTDOWN = 5'd1;
  localparam logic [KIND_W-1:0] EV_WORKER_START   = 5'd2;
  localparam logic [KIND_W-1:0] EV_WORKER_EXIT    = 5'd3;
  localparam logic [KIND_W-1:0] EV_GET_BLOCK      = 5'd4;
  localparam logic [KIND_W-1:0] EV_GOT_BLOCK      = 5'd5;
  localparam logic [KIND_W-1:0] EV_NO_BLOCK       = 5'd6;
  localparam logic [KIND_W-1:0] EV_WORKER_GATE    = 5'd7;
  localparam logic [KIND_W-1:0] EV_CTRL_GATE      = 5'd8;
  localparam logic [KIND_W-1:0] EV_GATE_RELEASE   = 5'd9;
  localparam logic [KIND_W-1:0] EV_WORKER_RESUME  = 5'd10;
  localparam logic [KIND_W-1:0] EV_CTRL_RESUME    = 5'd11;
  localparam logic [KIND_W-1:0] EV_BARRIER_WAIT   = 5'd12;
  localparam logic [KIND_W-1:0] EV_BARRIER_RESUME = 5'd13;
  localparam logic [KIND_W-1:0] EV_STRAND_START   = 5'd14;
  localparam logic [KIND_W-1:0] EV_STRAND_UPDATE  = 5'd15;
  localparam logic [KIND_W-1:0] EV_STRAND_DIE     = 5'd16;
  localparam logic [KIND_W-1:0] EV_STRAND_STAB    = 5'd17;

  typedef struct packed {
    logic [WID_W-1:0]  worker_id;
    logic [KIND_W-1:0] event_kind;
    logic [TS_W-1:0]   timestamp;
  } in_t;

  typedef struct packed {
    logic [WID_W-1:0] worker_out;
    logic [1:0]       current_state;
    logic [TS_W-1:0]  start_stamp;
    logic [TS_W-1:0]  end_stamp;
    logic [TS_W-1:0]  waiting_total;
    logic [TS_W-1:0]  running_total;
    logic [TS_W-1:0]  other_total;
    logic [CNT_W-1:0] block_count;
    logic [CNT_W-1:0] start_count;
    logic [CNT_W-1:0] update_count;
    logic [CNT_W-1:0] stabilize_count;
    logic [CNT_W-1:0] die_count;
  } out_t;

  typedef struct packed {
    logic     has_target;
    state_e_t target;
    effect_t  effect;
  } rule_t;

  // Classified event as it travels from the front to the back.
  typedef struct packed {
    logic [WID_W-1:0] worker_id;
    logic             in_range;
    logic             has_target;
    state_e_t         target;
    effect_t          effect;
    logic [TS_W-1:0]  timestamp;
  } cmd_t;

  // One worker's stored record.
  typedef struct packed {
    state_e_t         state;
    logic [TS_W-1:0]  last_change;
    logic [TS_W-1:0]  start_time;
    logic [TS_W-1:0]  end_time;
    logic [TS_W-1:0]  wait_accum;
    logic [TS_W-1:0]  run_accum;
    logic [TS_W-1:0]  other_accum;
    logic [CNT_W-1:0] blocks_seen;
    logic [CNT_W-1:0] starts_seen;
    logic [CNT_W-1:0] updates_seen;
    logic [CNT_W-1:0] stabilizes_seen;
    logic [CNT_W-1:0] dies_seen;
  } rec_t;

  function automatic rule_t classify(input logic [KIND_W-1:0] kind);
    rule_t r;
    r = '{has_target: 1'b1, target: ST_OTHER, effect: FX_NONE};
    case (kind)
      EV_SCHED_START:    r.effect = FX_START;
      EV_SCHED_SHUTDOWN: begin
        r.target = ST_DEAD;
        r.effect = FX_END;
      end
      EV_WORKER_START:   r.effect = FX_START;
      EV_WORKER_EXIT:    begin
        r.target = ST_DEAD;
        r.effect = FX_END;
      end
      EV_GET_BLOCK:      begin
        r.target = ST_WAIT;
        r.effect = FX_BLOCK;
      end
      EV_GOT_BLOCK:      begin
        r.target = ST_RUN;
        r.effect = FX_BLOCK;
      end
      EV_NO_BLOCK:       r.target = ST_OTHER;
      EV_WORKER_GATE:    r.target = ST_WAIT;
      EV_CTRL_GATE:      r.target = ST_WAIT;
      EV_WORKER_RESUME:  r.target = ST_OTHER;
      EV_CTRL_RESUME:    r.target = ST_OTHER;
      EV_BARRIER_WAIT:   r.target = ST_WAIT;
      EV_BARRIER_RESUME: r.target = ST_OTHER;
      EV_STRAND_START:   begin
        r.target = ST_RUN;
        r.effect = FX_SSTART;
      end
      EV_STRAND_UPDATE:  begin
        r.target = ST_RUN;
        r.effect = FX_SUPDATE;
      end
      EV_STRAND_DIE:     begin
        r.target = ST_RUN;
        r.effect = FX_SDIE;
      end
      EV_STRAND_STAB:    begin
        r.target = ST_RUN;
        r.effect = FX_SSTAB;
      end
      default:           r.has_target = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### design/wsrc_front.sv
// ----------------------------------------------------------------------------
// Worker state residency counter: front end
// Accepts events, checks the worker range and classifies the event kind.
// ----------------------------------------------------------------------------
module wsrc_front
  import wsrc_pkg::*;
#(
  parameter int NUM_WORKERS = DEF_WORKERS
) (
  input  logic clk,
  input  logic rst,
  input  in_t  evt,
  input  logic push,
  output logic full,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_item
);

  rule_t rule;
  logic  seen_item;

  always_comb begin
    rule                = classify(evt.event_kind);
    q_item.worker_id    = evt.worker_id;
    q_item.in_range     = (32'(evt.worker_id) < NUM_WORKERS);
    q_item.has_target   = rule.has_target;
    q_item.target       = rule.target;
    q_item.effect       = rule.effect;
    q_item.timestamp    = evt.timestamp;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  // Notes that at least one transfer has happened since reset; kept as
  // a status flag, which an assertion below checks stays set until reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_item <= 1'b0;
    end else if (q_push) begin
      seen_item <= 1'b1;
    end
  end

  `include "worker_state_residency_counter_core_defines.svh"

  `WSRC_ASSERT(a_push_not_full, q_push |-> !full, "front pushed into a full queue")
  `WSRC_ASSERT(a_seen_sticks, seen_item |=> seen_item, "transfer flag dropped without reset")

endmodule

### design/wsrc_fifo.sv
// ----------------------------------------------------------------------------
// Worker state residency counter: command queue
// Short queue of classified events between the front and the back.
// ----------------------------------------------------------------------------
module wsrc_fifo
  import wsrc_pkg::*;
#(
  parameter int DEPTH = DEF_Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic valid,
  output cmd_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  cmd_t               slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W_Q-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == CNT_W_Q'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/wsrc_back.sv
// ----------------------------------------------------------------------------
// Worker state residency counter: back end
// Read-modify-write of one worker record per event, and the result register.
// ----------------------------------------------------------------------------
module wsrc_back
  import wsrc_pkg::*;
#(
  parameter int NUM_WORKERS = DEF_WORKERS
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_item,
  output logic q_pop,
  output out_t record,
  output logic empty,
  input  logic pop
);

  localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPAN,
    S_WRITE
  } fsm_t;

  fsm_t                   state;
  cmd_t                   cur;
  rec_t                   mem [NUM_WORKERS];
  logic [NUM_WORKERS-1:0] vld;
  rec_t                   rd_rec;
  logic                   rd_hit;
  rec_t                   base;
  rec_t                   eff;
  rec_t                   work;
  rec_t                   rec_next;
  logic [TS_W:0]          diff;
  logic [TS_W-1:0]        span;
  logic                   ts_ge;
  logic                   do_change;
  logic                   out_valid;
  out_t                   out_data;
  out_t                   res_next;
  logic                   slot_free;
  logic                   wr_en;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       wr_idx;

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign rd_idx    = IDX_W'(q_item.worker_id);
  assign wr_idx    = IDX_W'(cur.worker_id);
  assign slot_free = !out_valid || pop;
  assign wr_en     = (state == S_WRITE) && slot_free && cur.in_range;
  assign empty     = !out_valid;
  assign record    = out_data;

  // Record memory: one read port, one write port, never used in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= rec_next;
    end
    if (q_pop) begin
      rd_rec <= mem[rd_idx];
    end
  end

  // A record never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (q_pop) begin
        rd_hit <= vld[rd_idx];
      end
    end
  end

  // Apply the event's side effect and find the elapsed span. The borrow of
  // the subtraction gives the timestamp ordering.
  always_comb begin
    base = rd_hit ? rd_rec : '0;
    eff  = base;
    case (cur.effect)
      FX_START:   eff.start_time      = cur.timestamp;
      FX_END:     eff.end_time        = cur.timestamp;
      FX_BLOCK:   eff.blocks_seen     = base.blocks_seen + 1'b1;
      FX_SSTART:  eff.starts_seen     = base.starts_seen + 1'b1;
      FX_SUPDATE: eff.updates_seen    = base.updates_seen + 1'b1;
      FX_SDIE:    eff.dies_seen       = base.dies_seen + 1'b1;
      FX_SSTAB:   eff.stabilizes_seen = base.stabilizes_seen + 1'b1;
      default:    eff = base;
    endcase
    diff = {1'b0, cur.timestamp} - {1'b0, base.last_change};
  end

  always_comb begin
    rec_next = work;
    if (do_change) begin
      if (ts_ge) begin
        case (work.state)
          ST_WAIT:  rec_next.wait_accum  = work.wait_accum + span;
          ST_RUN:   rec_next.run_accum   = work.run_accum + span;
          ST_OTHER: rec_next.other_accum = work.other_accum + span;
          default:  rec_next.last_change = cur.timestamp;
        endcase
        rec_next.last_change = cur.timestamp;
      end
      rec_next.state = cur.target;
    end
  end

  always_comb begin
    res_next            = '0;
    res_next.worker_out = cur.worker_id;
    if (cur.in_range) begin
      res_next.current_state   = rec_next.state;
      res_next.start_stamp     = rec_next.start_time;
      res_next.end_stamp       = rec_next.end_time;
      res_next.waiting_total   = rec_next.wait_accum;
      res_next.running_total   = rec_next.run_accum;
      res_next.other_total     = rec_next.other_accum;
      res_next.block_count     = rec_next.blocks_seen;
      res_next.start_count     = rec_next.starts_seen;
      res_next.update_count    = rec_next.updates_seen;
      res_next.stabilize_count = rec_next.stabilizes_seen;
      res_next.die_count       = rec_next.dies_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          work      <= eff;
          span      <= diff[TS_W-1:0];
          ts_ge     <= !diff[TS_W];
          do_change <= cur.has_target && (cur.target != base.state);
          state     <= S_WRITE;
        end
        S_WRITE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_data  <= res_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "worker_state_residency_counter_core_defines.svh"

  `WSRC_ASSERT(a_load_from_write, $rose(out_valid) |-> $past(state) == S_WRITE, "result loaded outside the write step")
  `WSRC_ASSERT_NEVER(a_write_out_of_range, wr_en && !cur.in_range, "record written for a worker out of range")
  `WSRC_ASSERT_NEVER(a_pop_while_busy, q_pop && (state != S_IDLE), "queue read while an event is in progress")
  `WSRC_ASSERT(a_write_sets_valid, wr_en |=> vld[$past(wr_idx)], "written record not marked valid")

endmodule

### design/worker_state_residency_counter_core.sv
// A result is ready once its event has passed the queue and the read, span and write steps;
// the write step waits while the result register is still full. The back end takes no new
// event until the last one is written; the queue absorbs short bursts.
// Reset (rst, synchronous): empties the queue and result register and marks every worker
// record invalid at once, so all records read as zero; there is no clearing pass.
// ----------------------------------------------------------------------------
// Worker state residency counter
// Per-worker residency accounting of timestamped scheduler events.
// ----------------------------------------------------------------------------
module worker_state_residency_counter_core
  import wsrc_pkg::*;
#(
  parameter int NUM_WORKERS = DEF_WORKERS,
  parameter int Q_DEPTH     = DEF_Q_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  in_t  evt,
  input  logic push,
  output logic full,
  output out_t record,
  output logic empty,
  input  logic pop
);

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_out;

  wsrc_front #(
    .NUM_WORKERS(NUM_WORKERS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt),
    .push   (push),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  wsrc_fifo #(
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .valid   (q_valid),
    .rd_data (q_out)
  );

  wsrc_back #(
    .NUM_WORKERS(NUM_WORKERS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .record  (record),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worker state residency counter testbench
// Drives timestamped scheduler events through the push side, predicts each
// worker record in step, and checks every popped record field by field.
// ----------------------------------------------------------------------------
module tb;
  import wsrc_pkg::*;

  localparam int NW = DEF_WORKERS;

  // Codes from this one up to the last are ignored by the block.
  localparam logic [KIND_W-1:0] EV_IGNORED_FIRST = 5'd18;
  localparam logic [KIND_W-1:0] EV_IGNORED_LAST  = 5'd31;

  typedef struct {
    in_t ev;
    bit  drain_first;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_t  evt = '0;
  logic push = 1'b0;
  logic full;
  out_t record;
  logic empty;
  logic pop = 1'b0;

  pending_t events_to_send[$];
  out_t     records_due[$];
  int       errors = 0;

  // Predicted per-worker records.
  state_e_t   res_state[NW];
  logic [63:0] res_last[NW];
  logic [63:0] res_start[NW];
  logic [63:0] res_end[NW];
  logic [63:0] res_wait[NW];
  logic [63:0] res_run[NW];
  logic [63:0] res_other[NW];
  logic [31:0] res_blocks[NW];
  logic [31:0] res_sstart[NW];
  logic [31:0] res_supdate[NW];
  logic [31:0] res_sstab[NW];
  logic [31:0] res_sdie[NW];

  int send_gap = 0;
  int send_calm = 0;
  int pop_wait = 0;
  int pop_calm = 0;

  worker_state_residency_counter_core #(.NUM_WORKERS(NW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .evt    (evt),
    .push   (push),
    .full   (full),
    .record (record),
    .empty  (empty),
    .pop    (pop)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(50, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_t account_event(in_t e);
    out_t        r;
    int unsigned w;
    logic        moves;
    state_e_t    tgt;
    logic [63:0] span;
    r = '0;
    r.worker_out = e.worker_id;
    w = 32'(e.worker_id);
    if (w >= NW) return r;

    case (e.event_kind)
      EV_SCHED_START, EV_WORKER_START:     res_start[w] = e.timestamp;
      EV_SCHED_SHUTDOWN, EV_WORKER_EXIT:   res_end[w] = e.timestamp;
      EV_GET_BLOCK, EV_GOT_BLOCK:          res_blocks[w] = res_blocks[w] + 1;
      EV_STRAND_START:                     res_sstart[w] = res_sstart[w] + 1;
      EV_STRAND_UPDATE:                    res_supdate[w] = res_supdate[w] + 1;
      EV_STRAND_DIE:                       res_sdie[w] = res_sdie[w] + 1;
      EV_STRAND_STAB:                      res_sstab[w] = res_sstab[w] + 1;
      default: ;
    endcase

    moves = 1'b1;
    tgt = ST_OTHER;
    case (e.event_kind)
      EV_SCHED_SHUTDOWN, EV_WORKER_EXIT: tgt = ST_DEAD;
      EV_GET_BLOCK, EV_WORKER_GATE, EV_CTRL_GATE, EV_BARRIER_WAIT: tgt = ST_WAIT;
      EV_GOT_BLOCK, EV_STRAND_START, EV_STRAND_UPDATE, EV_STRAND_DIE, EV_STRAND_STAB:
        tgt = ST_RUN;
      EV_SCHED_START, EV_WORKER_START, EV_NO_BLOCK, EV_WORKER_RESUME, EV_CTRL_RESUME,
      EV_BARRIER_RESUME: tgt = ST_OTHER;
      default: moves = 1'b0;
    endcase

    if (moves && tgt != res_state[w]) begin
      // An earlier timestamp moves the state but leaves the time base alone.
      if (e.timestamp >= res_last[w]) begin
        span = e.timestamp - res_last[w];
        case (res_state[w])
          ST_WAIT:  res_wait[w] = res_wait[w] + span;
          ST_RUN:   res_run[w] = res_run[w] + span;
          ST_OTHER: res_other[w] = res_other[w] + span;
          default: ;
        endcase
        res_last[w] = e.timestamp;
      end
      res_state[w] = tgt;
    end

    r.current_state   = res_state[w];
    r.start_stamp     = res_start[w];
    r.end_stamp       = res_end[w];
    r.waiting_total   = res_wait[w];
    r.running_total   = res_run[w];
    r.other_total     = res_other[w];
    r.block_count     = res_blocks[w];
    r.start_count     = res_sstart[w];
    r.update_count    = res_supdate[w];
    r.stabilize_count = res_sstab[w];
    r.die_count       = res_sdie[w];
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic enqueue_event(int w, logic [KIND_W-1:0] kind, logic [63:0] ts, bit drain);
    pending_t p;
    p.ev.worker_id  = w[WID_W-1:0];
    p.ev.event_kind = kind;
    p.ev.timestamp  = ts;
    p.drain_first   = drain;
    events_to_send.insert(events_to_send.size(), p);
  endtask

  // Driver: the item is predicted at the edge of its transfer.
  always @(posedge clk) begin
    logic nxt_push;
    in_t  nxt_evt;
    nxt_push = push;
    nxt_evt  = evt;
    if (rst) begin
      nxt_push = 1'b0;
    end else begin
      if (push && !full) begin
        records_due.insert(records_due.size(), account_event(evt));
        nxt_push = 1'b0;
      end
      if (!nxt_push) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (events_to_send.size() > 0 &&
                     !(events_to_send[0].drain_first && records_due.size() != 0)) begin
          nxt_evt  = events_to_send[0].ev;
          nxt_push = 1'b1;
          void'(events_to_send.pop_front());
          send_gap = pick_gap(send_calm);
        end
      end
    end
    push <= nxt_push;
    evt  <= nxt_evt;
  end

  // Monitor: checks each record taken by a transfer, then decides the next pop.
  always @(posedge clk) begin
    out_t want;
    logic nxt_pop;
    nxt_pop = 1'b0;
    if (!rst) begin
      if (pop && !empty) begin
        if (records_due.size() == 0) begin
          $error("record from worker %0d with nothing outstanding", record.worker_out);
          errors++;
        end else begin
          want = records_due.pop_front();
          check_field("worker_out", 64'(want.worker_out), 64'(record.worker_out));
          check_field("current_state", 64'(want.current_state), 64'(record.current_state));
          check_field("start_stamp", want.start_stamp, record.start_stamp);
          check_field("end_stamp", want.end_stamp, record.end_stamp);
          check_field("waiting_total", want.waiting_total, record.waiting_total);
          check_field("running_total", want.running_total, record.running_total);
          check_field("other_total", want.other_total, record.other_total);
          check_field("block_count", 64'(want.block_count), 64'(record.block_count));
          check_field("start_count", 64'(want.start_count), 64'(record.start_count));
          check_field("update_count", 64'(want.update_count), 64'(record.update_count));
          check_field("stabilize_count", 64'(want.stabilize_count),
                      64'(record.stabilize_count));
          check_field("die_count", 64'(want.die_count), 64'(record.die_count));
        end
      end
      if (pop_wait > 0) begin
        pop_wait--;
      end else begin
        nxt_pop  = 1'b1;
        pop_wait = pick_gap(pop_calm);
      end
    end
    pop <= nxt_pop;
  end

  initial begin
    logic [63:0]       cursor[NW];
    logic [63:0]       ts;
    logic [KIND_W-1:0] kind;
    int                w;
    int                r;

    for (int i = 0; i < NW; i++) begin
      res_state[i]   = ST_DEAD;
      res_last[i]    = '0;
      res_start[i]   = '0;
      res_end[i]     = '0;
      res_wait[i]    = '0;
      res_run[i]     = '0;
      res_other[i]   = '0;
      res_blocks[i]  = '0;
      res_sstart[i]  = '0;
      res_supdate[i] = '0;
      res_sstab[i]   = '0;
      res_sdie[i]    = '0;
      cursor[i]      = '0;
    end

    // Directed: a controller lifecycle touching every code but worker start and exit, then the extremes.
    enqueue_event(0, EV_SCHED_START, 64'd100, 1'b0);
    enqueue_event(0, EV_GOT_BLOCK, 64'd150, 1'b0);
    enqueue_event(0, EV_STRAND_START, 64'd160, 1'b0);
    enqueue_event(0, EV_STRAND_UPDATE, 64'd170, 1'b0);
    enqueue_event(0, EV_STRAND_DIE, 64'd180, 1'b0);
    enqueue_event(0, EV_STRAND_STAB, 64'd190, 1'b0);
    enqueue_event(0, EV_GET_BLOCK, 64'd400, 1'b0);
    enqueue_event(0, EV_GATE_RELEASE, 64'd450, 1'b0);
    enqueue_event(0, EV_IGNORED_LAST, 64'd460, 1'b0);
    enqueue_event(0, EV_IGNORED_FIRST, 64'd470, 1'b0);
    // Timestamp earlier than the last change: state moves, time does not.
    enqueue_event(0, EV_NO_BLOCK, 64'd10, 1'b0);
    enqueue_event(0, EV_WORKER_GATE, 64'd1000, 1'b0);
    enqueue_event(0, EV_CTRL_RESUME, 64'd1200, 1'b0);
    enqueue_event(0, EV_CTRL_GATE, 64'd1300, 1'b0);
    enqueue_event(0, EV_WORKER_RESUME, 64'd1350, 1'b0);
    enqueue_event(0, EV_BARRIER_WAIT, 64'd1400, 1'b0);
    enqueue_event(0, EV_BARRIER_RESUME, 64'd1500, 1'b0);
    enqueue_event(0, EV_SCHED_SHUTDOWN, 64'd2000, 1'b0);
    // Leaving dead at the top of the time range discards the dead span.
    enqueue_event(15, EV_WORKER_START, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    enqueue_event(15, EV_BARRIER_WAIT, 64'd0, 1'b0);
    enqueue_event(15, EV_GOT_BLOCK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    enqueue_event(15, EV_WORKER_EXIT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    enqueue_event(7, EV_STRAND_START, 64'h5555_AAAA_5555_AAAA, 1'b0);
    enqueue_event(7, EV_WORKER_EXIT, 64'hAAAA_5555_AAAA_5555, 1'b0);

    for (int n = 0; n < 1150; n++) begin
      r = $urandom_range(0, 99);
      if (r < 5) w = 0;
      else if (r < 10) w = NW - 1;
      else w = $urandom_range(0, NW - 1);

      r = $urandom_range(0, 99);
      if (r < 6) kind = ($urandom_range(0, 1) != 0) ? EV_SCHED_START : EV_WORKER_START;
      else if (r < 12) kind = ($urandom_range(0, 1) != 0) ? EV_SCHED_SHUTDOWN : EV_WORKER_EXIT;
      else if (r < 85) kind = KIND_W'($urandom_range(EV_GET_BLOCK, EV_STRAND_STAB));
      else if (r < 92) kind = EV_GATE_RELEASE;
      else kind = KIND_W'($urandom_range(EV_IGNORED_FIRST, EV_IGNORED_LAST));

      r = $urandom_range(0, 99);
      if (r < 78) begin
        cursor[w] = cursor[w] + $urandom_range(0, 2000);
        ts = cursor[w];
      end else if (r < 88) begin
        ts = cursor[w] - $urandom_range(1, 5000);
      end else if (r < 94) begin
        cursor[w] = {$urandom, $urandom};
        ts = cursor[w];
      end else if (r < 98) begin
        cursor[w] = cursor[w] + ({$urandom, $urandom} >> $urandom_range(0, 63));
        ts = cursor[w];
      end else begin
        ts = ($urandom_range(0, 1) != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
      end

      // Now and then the sender holds off until every record is back.
      enqueue_event(w, kind, ts, (n % 300) == 0);
    end

    // Sampled on the falling edge so that the driver's updates have settled.
    @(negedge rst);
    while (events_to_send.size() != 0 || push) @(negedge clk);
    while (records_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
